FILE: rtl/min_priority_queue_defines.svh
// Assertion macros shared by the verification files of the priority queue.
// Depends on nothing; included by the checker module.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mpq_pkg.sv
// Shared types and constants for the priority queue.
// No dependencies; imported by every module of the block.
package mpq_pkg;

    localparam int KEY_W           = 32;
    localparam int NODE_W          = 8;
    localparam int ENTRY_W         = KEY_W + NODE_W;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 5;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic insert;       // append entry, report inserted
        logic full;         // report full
        logic empty;        // report empty
        logic scan_start;   // rewind read pointer to head
        logic scan_step;    // read one entry for the min scan
        logic cmp_en;       // compare stage active
        logic shift_start;  // point read pointer just past the minimum
        logic shift_step;   // read one entry for gap closing
        logic shift_wr;     // write stage active (one slot toward head)
        logic finish;       // drop count, report extracted
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_full;
        logic is_empty;
        logic scan_last;    // current read is the last held entry
        logic shift_more;   // entries left to move
    } t_dp_stat;

endpackage

FILE: rtl/min_priority_queue.sv
// Top level of the unsorted-list min priority queue.
// Depends on mpq_pkg, mpq_ctrl and mpq_datapath.
// Usage:
//  - Request channel: drive i_req_type/i_new_key/i_node_id with start high; the
//    transaction is taken at a rising edge where start is high and busy is low.
//    i_req_type = 0 inserts (key, node id) at the tail, 1 extracts the entry with
//    the smallest signed key (earliest inserted wins a tie).
//  - Result channel: o_valid pulses for exactly one cycle with o_status,
//    o_out_key, o_out_node and o_entry_count. The receiver cannot stall; the
//    result must be taken in that cycle.
//  - Insert, insert-when-full and extract-when-empty give their result in the
//    cycle after the transaction, and busy stays low, so one such request per
//    cycle is accepted.
//  - Extract with entries held: the scan state reads every held entry through
//    the single memory read port, a flush state empties the compare stage, a
//    setup state points the read pointer past the minimum, the shift state
//    moves each later entry one slot toward the head, and a drain state
//    reports the result; o_valid pulses in the first cycle with busy low again.
//  - Reset (synchronous, active low) empties the queue and idles the sequencer;
//    the stored entries themselves are not cleared.
module min_priority_queue import mpq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_req_type,
    input  logic [KEY_W-1:0]    i_new_key,
    input  logic [NODE_W-1:0]   i_node_id,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_out_key,
    output logic [NODE_W-1:0]   o_out_node,
    output logic [COUNT_W-1:0]  o_entry_count
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: request decode and scan/shift phases
    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    // entry store, min tracking and result registers
    mpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_new_key     (i_new_key),
        .i_node_id     (i_node_id),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_node    (o_out_node),
        .o_entry_count (o_entry_count)
    );

endmodule

FILE: rtl/mpq_ctrl.sv
// Sequencer for the priority queue: decodes requests and walks scan/shift phases.
// Depends on mpq_pkg; drives the command struct of mpq_datapath.
module mpq_ctrl import mpq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_req_type,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_FLUSH = 6'b000100,
        S_SETUP = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == REQ_INSERT) begin
                        if (i_stat.is_full) begin
                            o_cmd.full = 1'b1;
                        end else begin
                            o_cmd.insert = 1'b1;
                        end
                    end else if (i_stat.is_empty) begin
                        o_cmd.empty = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.cmp_en    = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // last read still in the compare stage
                o_cmd.cmp_en = 1'b1;
                n_state      = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.shift_start = 1'b1;
                n_state           = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (i_stat.shift_more) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.finish   = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/mpq_datapath.sv
// Entry store, read/compare/write pipeline and result registers of the queue.
// Depends on mpq_pkg; commanded by mpq_ctrl.
module mpq_datapath import mpq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_W-1:0]    i_new_key,
    input  logic [NODE_W-1:0]   i_node_id,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_out_key,
    output logic [NODE_W-1:0]   o_out_node,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0]       r_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_pidx;
    logic                     r_pv;
    logic [ENTRY_W-1:0]       r_rdata;
    logic signed [KEY_W-1:0]  r_best_key;
    logic [NODE_W-1:0]        r_best_node;
    logic [IDX_W-1:0]         r_best_idx;

    logic                     r_valid;
    t_status                  r_status;
    logic [KEY_W-1:0]         r_key;
    logic [NODE_W-1:0]        r_node;
    logic [COUNT_W-1:0]       r_ecount;

    logic signed [KEY_W-1:0]  w_rd_key;
    logic                     w_take;
    logic [CNT_W-1:0]         n_res_cnt;
    logic [CNT_W+COUNT_W-1:0] w_cnt_ext;

    assign w_rd_key = $signed(r_rdata[ENTRY_W-1:NODE_W]);
    // strict compare: earliest of equal keys stays
    assign w_take   = i_cmd.cmp_en && r_pv && ((r_pidx == '0) || (w_rd_key < r_best_key));

    assign o_stat.is_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.is_empty   = (r_count == '0);
    assign o_stat.scan_last  = (r_idx == (r_count - CNT_W'(1)));
    assign o_stat.shift_more = (r_idx < r_count);

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_new_key, i_node_id};
        end else if (i_cmd.shift_wr && r_pv) begin
            r_mem[r_pidx - IDX_W'(1)] <= r_rdata;
        end
        if (i_cmd.scan_step || i_cmd.shift_step) begin
            r_rdata <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_res_cnt = r_count;
        if (i_cmd.insert) begin
            n_res_cnt = r_count + CNT_W'(1);
        end else if (i_cmd.empty) begin
            n_res_cnt = '0;
        end else if (i_cmd.finish) begin
            n_res_cnt = r_count - CNT_W'(1);
        end
    end

    assign w_cnt_ext = (CNT_W + COUNT_W)'(n_res_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_res_cnt;
            r_pv    <= i_cmd.scan_step || i_cmd.shift_step;
            r_valid <= i_cmd.insert || i_cmd.full || i_cmd.empty || i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.shift_start) begin
            r_idx <= CNT_W'(r_best_idx) + CNT_W'(1);
        end else if (i_cmd.scan_step || i_cmd.shift_step) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.scan_step || i_cmd.shift_step) begin
            r_pidx <= r_idx[IDX_W-1:0];
        end
        if (w_take) begin
            r_best_key  <= w_rd_key;
            r_best_node <= r_rdata[NODE_W-1:0];
            r_best_idx  <= r_pidx;
        end
        if (i_cmd.insert || i_cmd.full || i_cmd.empty || i_cmd.finish) begin
            r_ecount <= w_cnt_ext[COUNT_W-1:0];
            if (i_cmd.finish) begin
                r_status <= ST_EXTRACTED;
                r_key    <= r_best_key;
                r_node   <= r_best_node;
            end else begin
                r_key  <= '0;
                r_node <= '0;
                if (i_cmd.insert) begin
                    r_status <= ST_INSERTED;
                end else if (i_cmd.full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_EMPTY;
                end
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_key;
    assign o_out_node    = r_node;
    assign o_entry_count = r_ecount;

endmodule

FILE: rtl/mpq_checker.sv
// Port-level checker for the priority queue, bound to min_priority_queue.
// Depends on mpq_pkg and min_priority_queue_defines.svh.
`include "min_priority_queue_defines.svh"

module mpq_checker import mpq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_req_type,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [KEY_W-1:0]    o_out_key,
    input logic [NODE_W-1:0]   o_out_node,
    input logic [COUNT_W-1:0]  o_entry_count
);

    // insert transactions always answer in the next cycle
    `MPQ_ASSERT_NXT(a_insert_answer, i_clk, i_rst_n, start && !busy && (i_req_type == REQ_INSERT), o_valid && !busy, "insert result not delivered next cycle")
    // extract either answers at once (empty) or starts working
    `MPQ_ASSERT_NXT(a_extract_progress, i_clk, i_rst_n, start && !busy && (i_req_type == REQ_EXTRACT), o_valid || busy, "extract neither answered nor started")
    // only an extracted result carries a key and node id
    `MPQ_ASSERT_IMP(a_zero_payload, i_clk, i_rst_n, o_valid && (o_status != ST_EXTRACTED), (o_out_key == '0) && (o_out_node == '0), "non-extract result has nonzero payload")
    // empty report shows no entries, insert report shows at least one
    `MPQ_ASSERT_IMP(a_count_status, i_clk, i_rst_n, o_valid && ((o_status == ST_EMPTY) || (o_status == ST_INSERTED)), (o_status == ST_EMPTY) == (o_entry_count == '0), "entry count inconsistent with status")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_out_key     (o_out_key),
    .o_out_node    (o_out_node),
    .o_entry_count (o_entry_count)
);
